// ----- sv/sssd_pkg.sv -----
// Package for the seven-segment scan display: widths, request codes, the item
// that travels down the cell chain, and the 0-F segment table.
// No dependencies.
`timescale 1ns / 1ps

package sssd_pkg;

    // Number of digits loaded and scanned (1 to 4).
    localparam int NUM_DIGITS = 4;

    localparam int VAL_W = 16;
    localparam int IDX_W = 2;
    localparam int EN_W  = 4;
    localparam int SEG_W = 8;
    localparam int DIG_W = 4;

    // Request codes carried in req_type.
    localparam logic REQ_SCAN = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    localparam logic [SEG_W-1:0] PATTERN_RESET = 8'hFF;

    // Exact division by ten for 16-bit values: (q * 52429) >> 19.
    localparam int DIV10_MAG_W = 17;
    localparam logic [DIV10_MAG_W-1:0] DIV10_MAGIC = 17'd52429;
    localparam int DIV10_SHIFT = 19;
    localparam int PROD_W = VAL_W + DIV10_MAG_W;

    // One request on its way through the chain of digit cells.
    typedef struct packed {
        logic              load;
        logic              hex;
        logic [VAL_W-1:0]  quot;
        logic [IDX_W-1:0]  scan_idx;
        logic [SEG_W-1:0]  seg;
    } t_item;

    function automatic logic [SEG_W-1:0] seg_lookup(input logic [DIG_W-1:0] d);
        logic [SEG_W-1:0] p;
        unique case (d)
            4'h0: p = 8'h3F;
            4'h1: p = 8'h06;
            4'h2: p = 8'h5B;
            4'h3: p = 8'h4F;
            4'h4: p = 8'h66;
            4'h5: p = 8'h6D;
            4'h6: p = 8'h7D;
            4'h7: p = 8'h07;
            4'h8: p = 8'h7F;
            4'h9: p = 8'h6F;
            4'hA: p = 8'h77;
            4'hB: p = 8'h7C;
            4'hC: p = 8'h39;
            4'hD: p = 8'h5E;
            4'hE: p = 8'h79;
            4'hF: p = 8'h71;
            default: p = PATTERN_RESET;
        endcase
        return p;
    endfunction

endpackage

// ----- sv/sssd_in_if.sv -----
// Request channel of the seven-segment scan display.
// Depends on sssd_pkg for field widths.
`timescale 1ns / 1ps

interface sssd_in_if;
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic [sssd_pkg::VAL_W-1:0]   value;
    logic                         show_hex;

    modport source (output valid, output req_type, output value, output show_hex,
                    input ready);
    modport sink   (input valid, input req_type, input value, input show_hex,
                    output ready);
endinterface

// ----- sv/sssd_out_if.sv -----
// Result channel of the seven-segment scan display.
// Depends on sssd_pkg for field widths.
`timescale 1ns / 1ps

interface sssd_out_if;
    logic                         valid;
    logic                         ready;
    logic [sssd_pkg::EN_W-1:0]    digit_enable;
    logic [sssd_pkg::SEG_W-1:0]   segments;

    modport source (output valid, output digit_enable, output segments,
                    input ready);
    modport sink   (input valid, input digit_enable, input segments,
                    output ready);
endinterface

// ----- sv/sssd_cell.sv -----
// One digit cell of the display chain: holds one digit pattern, peels one
// digit off a passing load and hands a passing scan its pattern if selected.
// Depends on sssd_pkg.
`timescale 1ns / 1ps

module sssd_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [sssd_pkg::IDX_W-1:0]    i_cell_index,
    input  logic                          i_valid,
    input  sssd_pkg::t_item               i_item,
    output logic                          o_ready,
    output logic                          o_valid,
    output sssd_pkg::t_item               o_item,
    input  logic                          i_ready
);

    logic                               r_valid;
    sssd_pkg::t_item                    r_item;
    logic [sssd_pkg::SEG_W-1:0]         r_pattern;

    logic [sssd_pkg::PROD_W-1:0]        w_prod;
    logic [sssd_pkg::VAL_W-1:0]         w_quot10;
    logic [sssd_pkg::VAL_W-1:0]         w_times10;
    logic [sssd_pkg::VAL_W-1:0]         w_rem;
    logic [sssd_pkg::DIG_W-1:0]         w_digit;
    logic                               w_move;

    assign w_move  = r_valid && i_ready;
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;

    // Divide by ten through the reciprocal, then recover the remainder.
    assign w_prod    = sssd_pkg::PROD_W'(r_item.quot) * sssd_pkg::PROD_W'(sssd_pkg::DIV10_MAGIC);
    assign w_quot10  = sssd_pkg::VAL_W'(w_prod >> sssd_pkg::DIV10_SHIFT);
    assign w_times10 = (w_quot10 << 3) + (w_quot10 << 1);
    assign w_rem     = r_item.quot - w_times10;
    assign w_digit   = r_item.hex ? r_item.quot[sssd_pkg::DIG_W-1:0]
                                  : w_rem[sssd_pkg::DIG_W-1:0];

    always_comb begin
        o_item      = r_item;
        o_item.quot = r_item.hex ? (r_item.quot >> sssd_pkg::DIG_W) : w_quot10;
        if (!r_item.load && (r_item.scan_idx == i_cell_index)) begin
            o_item.seg = r_pattern;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_pattern <= sssd_pkg::PATTERN_RESET;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (w_move && r_item.load) begin
                r_pattern <= sssd_pkg::seg_lookup(w_digit);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ----- sv/sssd_drive.sv -----
// Output stage: holds the enable and segment drive and offers it as the result.
// Depends on sssd_pkg and sssd_out_if.
`timescale 1ns / 1ps

module sssd_drive (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  sssd_pkg::t_item   i_item,
    output logic              o_ready,
    sssd_out_if.source        o_res
);

    logic                          r_out_valid;
    logic [sssd_pkg::EN_W-1:0]     r_enable_drive;
    logic [sssd_pkg::SEG_W-1:0]    r_segment_drive;
    logic                          w_take;

    assign o_ready = !r_out_valid || o_res.ready;
    assign w_take  = i_valid && o_ready;

    assign o_res.valid        = r_out_valid;
    assign o_res.digit_enable = r_enable_drive;
    assign o_res.segments     = r_segment_drive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid     <= 1'b0;
            r_enable_drive  <= '0;
            r_segment_drive <= '0;
        end else begin
            if (o_ready) begin
                r_out_valid <= i_valid;
            end
            // A load leaves the drive as it is; a scan lights its digit.
            if (w_take && !i_item.load) begin
                r_enable_drive  <= sssd_pkg::EN_W'(1) << i_item.scan_idx;
                r_segment_drive <= i_item.seg;
            end
        end
    end

endmodule

// ----- sv/seven_segment_scan_display.sv -----
// Seven-segment scan display driver for up to four multiplexed digits. Every
// request returns one result: the enable and segment drive after the request.
// A load request (req_type 1) converts value into digit patterns, four decimal
// digits (the ten-thousands digit is dropped) or four hex nibbles, with
// pattern 0 the most significant digit; its result repeats the present drive.
// A scan request (req_type 0) lights the next digit with a one-hot enable and
// its pattern. Patterns start as 0xFF and the drive as zero after reset. The
// block accepts one request per clock cycle while the result channel takes its
// results; each request passes through the row of digit cells, one cell per
// cycle unless the result channel holds it back, and then the output register.
// Depends on sssd_pkg, sssd_in_if, sssd_out_if, sssd_cell and sssd_drive.
`timescale 1ns / 1ps

module seven_segment_scan_display (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sssd_in_if.sink       i_req,
    sssd_out_if.source    o_res
);

    localparam int N = sssd_pkg::NUM_DIGITS;

    // Scan position of the next scan request, advanced as scan requests enter so
    // that every scan carries its own digit index down the chain.
    logic [sssd_pkg::IDX_W-1:0]   r_scan_index;
    logic [sssd_pkg::IDX_W-1:0]   n_scan_index;

    logic                         w_valid [N+1];
    logic                         w_ready [N+1];
    sssd_pkg::t_item              w_item  [N+1];
    logic                         w_accept;

    assign w_accept    = i_req.valid && i_req.ready;
    assign i_req.ready = w_ready[0];

    // The entering request. Loads carry the value as the running quotient;
    // the segment field is filled in by the cell that the scan selects.
    always_comb begin
        w_valid[0]         = i_req.valid;
        w_item[0].load     = (i_req.req_type == sssd_pkg::REQ_LOAD);
        w_item[0].hex      = i_req.show_hex;
        w_item[0].quot     = i_req.value;
        w_item[0].scan_idx = r_scan_index;
        w_item[0].seg      = '0;
    end

    always_comb begin
        if (r_scan_index == sssd_pkg::IDX_W'(N - 1)) begin
            n_scan_index = '0;
        end else begin
            n_scan_index = r_scan_index + sssd_pkg::IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_index <= '0;
        end else if (w_accept && (i_req.req_type == sssd_pkg::REQ_SCAN)) begin
            r_scan_index <= n_scan_index;
        end
    end

    // Cell s owns pattern NUM_DIGITS-1-s, so a load peels off the least
    // significant digit in the first cell and the most significant in the last.
    for (genvar s = 0; s < N; s++) begin : g_cell
        sssd_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cell_index (sssd_pkg::IDX_W'(N - 1 - s)),
            .i_valid      (w_valid[s]),
            .i_item       (w_item[s]),
            .o_ready      (w_ready[s]),
            .o_valid      (w_valid[s+1]),
            .o_item       (w_item[s+1]),
            .i_ready      (w_ready[s+1])
        );
    end

    sssd_drive u_drive (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[N]),
        .i_item  (w_item[N]),
        .o_ready (w_ready[N]),
        .o_res   (o_res)
    );

    // The scan position never leaves the range of configured digits.
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan_index <= sssd_pkg::IDX_W'(N - 1))
        else $error("scan index beyond last digit");

    // At most one digit is ever lit.
    a_enable_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> $onehot0(o_res.digit_enable))
        else $error("more than one digit enabled");

    // An accepted request occupies the first cell on the next cycle.
    a_enter_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> w_valid[1])
        else $error("accepted request lost at chain entry");

    // A lit digit always has an index inside the scanned range.
    a_enable_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> ((o_res.digit_enable >> N) == '0))
        else $error("enable outside scanned digits");

endmodule
